// ----- rtl/qte_pkg.sv -----
// Shared types, widths and the CORDIC angle table for the quaternion to Euler block.
`timescale 1ns / 1ps
package qte_pkg;

  // Width of the atan2 operands (numerators and denominators).
  localparam int OP_W = 36;
  // Width of the rescaled arcsine argument, 30 fraction bits.
  localparam int TN_W = 32;
  // Fraction bits of the arcsine argument.
  localparam int WORK_BITS = 30;
  // Width of the square root radicand.
  localparam int SQ_W = 63;
  // Number of steps of the integer square root (one result bit each).
  localparam int SQRT_STEPS = 32;
  // Width of the root itself.
  localparam int ROOT_W = 31;
  // Angle accumulator: degrees with 16 fraction bits.
  localparam int ANG_W = 26;
  // Width of the side payload that travels beside the square root.
  localparam int SIDE_W = 1 + TN_W + 4 * OP_W;

  typedef logic signed [OP_W-1:0]  op_t;
  typedef logic signed [TN_W-1:0]  tn_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  // atan(2^-i) in degrees, 16 fraction bits.
  function automatic ang_t atan_deg(input int i);
    ang_t a;
    case (i)
      0:  a = 26'sd2949120;
      1:  a = 26'sd1740967;
      2:  a = 26'sd919879;
      3:  a = 26'sd466945;
      4:  a = 26'sd234379;
      5:  a = 26'sd117304;
      6:  a = 26'sd58666;
      7:  a = 26'sd29335;
      8:  a = 26'sd14668;
      9:  a = 26'sd7334;
      10: a = 26'sd3667;
      11: a = 26'sd1833;
      12: a = 26'sd917;
      13: a = 26'sd458;
      14: a = 26'sd229;
      15: a = 26'sd115;
      16: a = 26'sd57;
      17: a = 26'sd29;
      18: a = 26'sd14;
      19: a = 26'sd7;
      20: a = 26'sd4;
      21: a = 26'sd2;
      22: a = 26'sd1;
      default: a = 26'sd0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/qte_prep.sv -----
// Front end: component products, atan2 operands, arcsine argument clamp and radicand.
`timescale 1ns / 1ps
module qte_prep #(
  parameter int COMPONENT_FRACTION_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [15:0]   quat_w,
  input  logic signed [15:0]   quat_x,
  input  logic signed [15:0]   quat_y,
  input  logic signed [15:0]   quat_z,
  output logic                 valid,
  output qte_pkg::op_t         roll_n,
  output qte_pkg::op_t         roll_d,
  output qte_pkg::op_t         yaw_n,
  output qte_pkg::op_t         yaw_d,
  output qte_pkg::tn_t         tn,
  output logic                 clamped,
  output logic [qte_pkg::SQ_W-1:0] radicand
);
  import qte_pkg::*;

  localparam int TWO_F = 2 * COMPONENT_FRACTION_BITS;
  localparam int SH_R = (TWO_F >= WORK_BITS) ? TWO_F - WORK_BITS : 0;
  localparam int SH_L = (TWO_F >= WORK_BITS) ? 0 : WORK_BITS - TWO_F;
  localparam logic signed [63:0] UNIT = 64'sd1 <<< TWO_F;
  localparam logic signed [63:0] LIM  = 64'sd1 <<< WORK_BITS;

  // Stage 1: the ten component products.
  logic signed [31:0] p_ww, p_xx, p_yy, p_zz, p_yz, p_xw, p_xy, p_zw, p_xz, p_yw;
  logic v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ww <= quat_w * quat_w;
      p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y;
      p_zz <= quat_z * quat_z;
      p_yz <= quat_y * quat_z;
      p_xw <= quat_x * quat_w;
      p_xy <= quat_x * quat_y;
      p_zw <= quat_z * quat_w;
      p_xz <= quat_x * quat_z;
      p_yw <= quat_y * quat_w;
    end
  end

  // Stage 2: sums that form the atan2 operands and the arcsine argument.
  op_t rn2, rd2, yn2, yd2, s2;
  logic v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rn2 <= (OP_W'(p_yz) + OP_W'(p_xw)) <<< 1;
      rd2 <= OP_W'(p_ww) - OP_W'(p_xx) - OP_W'(p_yy) + OP_W'(p_zz);
      yn2 <= (OP_W'(p_xy) + OP_W'(p_zw)) <<< 1;
      yd2 <= OP_W'(p_ww) + OP_W'(p_xx) - OP_W'(p_yy) - OP_W'(p_zz);
      s2  <= (OP_W'(p_yw) - OP_W'(p_xz)) <<< 1;
    end
  end

  // Stage 3: clamp the arcsine argument to unit and rescale it to 30 fraction bits.
  logic signed [63:0] s_wide, s_clip, t_wide;
  logic               clip;

  always_comb begin
    s_wide = 64'(s2);
    clip   = 1'b0;
    s_clip = s_wide;
    if (s_wide > UNIT) begin
      s_clip = UNIT;
      clip   = 1'b1;
    end else if (s_wide < -UNIT) begin
      s_clip = -UNIT;
      clip   = 1'b1;
    end
    if (TWO_F >= WORK_BITS) begin
      t_wide = s_clip >>> SH_R;
    end else begin
      t_wide = s_clip <<< SH_L;
    end
    if (t_wide > LIM) begin
      t_wide = LIM;
    end else if (t_wide < -LIM) begin
      t_wide = -LIM;
    end
  end

  op_t  rn3, rd3, yn3, yd3;
  tn_t  tn3;
  logic clip3, v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rn3   <= rn2;
      rd3   <= rd2;
      yn3   <= yn2;
      yd3   <= yd2;
      tn3   <= TN_W'(t_wide);
      clip3 <= clip;
    end
  end

  // Stage 4: radicand 1 - t^2 for the cosine of pitch.
  logic signed [63:0] t_sq, rad_wide;

  always_comb begin
    t_sq     = tn3 * tn3;
    rad_wide = (64'sd1 <<< (2 * WORK_BITS)) - t_sq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_n   <= rn3;
      roll_d   <= rd3;
      yaw_n    <= yn3;
      yaw_d    <= yd3;
      tn       <= tn3;
      clamped  <= clip3;
      radicand <= SQ_W'(rad_wide);
    end
  end

endmodule

// ----- rtl/qte_isqrt.sv -----
// Pipelined floor integer square root, one result bit per stage, with a side payload.
`timescale 1ns / 1ps
module qte_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [qte_pkg::SQ_W-1:0]      radicand,
  input  logic [qte_pkg::SIDE_W-1:0]    side_in,
  output logic                          valid,
  output logic [qte_pkg::ROOT_W-1:0]    root,
  output logic [qte_pkg::SIDE_W-1:0]    side_out
);
  import qte_pkg::*;

  logic [SQ_W-1:0]   rem_s  [0:SQRT_STEPS];
  logic [SQ_W-1:0]   res_s  [0:SQRT_STEPS];
  logic [SIDE_W-1:0] side_s [0:SQRT_STEPS];
  logic              vld_s  [0:SQRT_STEPS];

  assign rem_s[0]  = radicand;
  assign res_s[0]  = '0;
  assign side_s[0] = side_in;
  assign vld_s[0]  = in_valid;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 1 - 2 * k);
    logic [SQ_W-1:0] trial, rem_next, res_next;

    // Try to subtract the next root bit.
    always_comb begin
      trial = res_s[k] + BIT;
      if (rem_s[k] >= trial) begin
        rem_next = rem_s[k] - trial;
        res_next = (res_s[k] >> 1) + BIT;
      end else begin
        rem_next = rem_s[k];
        res_next = res_s[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (en) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1]  <= rem_next;
        res_s[k+1]  <= res_next;
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign valid    = vld_s[SQRT_STEPS];
  assign root     = res_s[SQRT_STEPS][ROOT_W-1:0];
  assign side_out = side_s[SQRT_STEPS];

endmodule

// ----- rtl/qte_cordic.sv -----
// Unrolled vectoring CORDIC atan2 in degrees, rounded and saturated to 7 fraction bits.
`timescale 1ns / 1ps
module qte_cordic #(
  parameter int ITER  = 16,
  parameter int LIM   = 23040,
  parameter int OUT_W = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  qte_pkg::op_t             y_in,
  input  qte_pkg::op_t             x_in,
  output logic                     valid,
  output logic signed [OUT_W-1:0]  angle
);
  import qte_pkg::*;

  localparam int XW = OP_W + 2;
  localparam logic signed [ANG_W-1:0] A90  = ANG_W'(90 * 65536);
  localparam logic signed [ANG_W-1:0] A180 = ANG_W'(180 * 65536);
  localparam logic signed [ANG_W-1:0] LIM_A = ANG_W'(LIM);

  logic signed [XW-1:0]    x_s [0:ITER];
  logic signed [XW-1:0]    y_s [0:ITER];
  ang_t                    z_s [0:ITER];
  logic                    sp_s [0:ITER];
  logic                    vld_s [0:ITER];

  // Axis cases and the quadrant fold for a negative x.
  logic signed [XW-1:0] xe, ye, x0, y0;
  ang_t                 z0;
  logic                 sp0;

  always_comb begin
    xe  = XW'(x_in);
    ye  = XW'(y_in);
    x0  = xe;
    y0  = ye;
    z0  = '0;
    sp0 = 1'b0;
    if (ye == '0) begin
      sp0 = 1'b1;
      z0  = (xe >= 0) ? '0 : A180;
    end else if (xe == '0) begin
      sp0 = 1'b1;
      z0  = (ye > 0) ? A90 : -A90;
    end else if (xe < 0) begin
      if (ye > 0) begin
        x0 = ye;
        y0 = -xe;
        z0 = A90;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -A90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
    end else if (en) begin
      vld_s[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_s[0]  <= x0;
      y_s[0]  <= y0;
      z_s[0]  <= z0;
      sp_s[0] <= sp0;
    end
  end

  // One micro-rotation per stage; axis cases pass through untouched.
  for (genvar i = 0; i < ITER; i++) begin : g_iter
    localparam ang_t ATAN_I = atan_deg(i);
    logic signed [XW-1:0] x_next, y_next;
    ang_t                 z_next;

    always_comb begin
      x_next = x_s[i];
      y_next = y_s[i];
      z_next = z_s[i];
      if (!sp_s[i]) begin
        if (y_s[i] > 0) begin
          x_next = x_s[i] + (y_s[i] >>> i);
          y_next = y_s[i] - (x_s[i] >>> i);
          z_next = z_s[i] + ATAN_I;
        end else begin
          x_next = x_s[i] - (y_s[i] >>> i);
          y_next = y_s[i] + (x_s[i] >>> i);
          z_next = z_s[i] - ATAN_I;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i+1] <= 1'b0;
      end else if (en) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_s[i+1]  <= x_next;
        y_s[i+1]  <= y_next;
        z_s[i+1]  <= z_next;
        sp_s[i+1] <= sp_s[i];
      end
    end
  end

  // Round half up to 7 fraction bits and saturate.
  ang_t r;

  always_comb begin
    r = (z_s[ITER] + ANG_W'(256)) >>> 9;
    if (r > LIM_A) begin
      r = LIM_A;
    end else if (r < -LIM_A) begin
      r = -LIM_A;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= vld_s[ITER];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= OUT_W'(r);
    end
  end

endmodule

// ----- rtl/quaternion_to_euler_degrees_core.sv -----
// Top level: unit quaternion in, roll, pitch and yaw in degrees out.
`timescale 1ns / 1ps
// Converts one Q1.14 quaternion per clock while the output is not stalled into roll,
// pitch and yaw in degrees with 128 units per degree. The block is a fully pipelined
// datapath: a new request can be accepted every cycle unless the output stalls, and
// results come out in order through 4 front-end stages, 32 square-root stages, and
// CORDIC_ITERATIONS + 2 stages of the three parallel CORDIC units. Pitch is found as
// atan2(t, sqrt(1 - t^2)); when the arcsine argument exceeds unit magnitude it is
// clamped and pitch_clamped is set. A stall on the output holds the whole pipeline.
module quaternion_to_euler_degrees_core #(
  parameter int CORDIC_ITERATIONS       = 16,
  parameter int COMPONENT_FRACTION_BITS = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  quat_w,
  input  logic signed [15:0]  quat_x,
  input  logic signed [15:0]  quat_y,
  input  logic signed [15:0]  quat_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  roll_deg,
  output logic signed [14:0]  pitch_deg,
  output logic signed [15:0]  yaw_deg,
  output logic                pitch_clamped
);
  import qte_pkg::*;

  // The pipeline advances whenever the output register is empty or being taken.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Front end.
  logic                p_valid, p_clamped;
  op_t                 p_rn, p_rd, p_yn, p_yd;
  tn_t                 p_tn;
  logic [SQ_W-1:0]     p_rad;

  qte_prep #(
    .COMPONENT_FRACTION_BITS(COMPONENT_FRACTION_BITS)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .quat_w   (quat_w),
    .quat_x   (quat_x),
    .quat_y   (quat_y),
    .quat_z   (quat_z),
    .valid    (p_valid),
    .roll_n   (p_rn),
    .roll_d   (p_rd),
    .yaw_n    (p_yn),
    .yaw_d    (p_yd),
    .tn       (p_tn),
    .clamped  (p_clamped),
    .radicand (p_rad)
  );

  // Square root, with the other operands carried alongside.
  logic                s_valid;
  logic [ROOT_W-1:0]   s_root;
  logic [SIDE_W-1:0]   s_side;
  logic                s_clamped;
  op_t                 s_rn, s_rd, s_yn, s_yd;
  tn_t                 s_tn;

  qte_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (p_valid),
    .radicand (p_rad),
    .side_in  ({p_clamped, p_tn, p_rn, p_rd, p_yn, p_yd}),
    .valid    (s_valid),
    .root     (s_root),
    .side_out (s_side)
  );

  assign {s_clamped, s_tn, s_rn, s_rd, s_yn, s_yd} = s_side;

  // Three atan2 units in parallel.
  logic r_valid, p_ang_valid, y_valid;

  qte_cordic #(
    .ITER  (CORDIC_ITERATIONS),
    .LIM   (23040),
    .OUT_W (16)
  ) u_roll (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_valid),
    .y_in     (s_rn),
    .x_in     (s_rd),
    .valid    (r_valid),
    .angle    (roll_deg)
  );

  qte_cordic #(
    .ITER  (CORDIC_ITERATIONS),
    .LIM   (11520),
    .OUT_W (15)
  ) u_pitch (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_valid),
    .y_in     (OP_W'(s_tn)),
    .x_in     (OP_W'({1'b0, s_root})),
    .valid    (p_ang_valid),
    .angle    (pitch_deg)
  );

  qte_cordic #(
    .ITER  (CORDIC_ITERATIONS),
    .LIM   (23040),
    .OUT_W (16)
  ) u_yaw (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_valid),
    .y_in     (s_yn),
    .x_in     (s_yd),
    .valid    (y_valid),
    .angle    (yaw_deg)
  );

  assign out_valid = r_valid && p_ang_valid && y_valid;

  // Clamp flag delay matching the CORDIC depth.
  localparam int CD = CORDIC_ITERATIONS + 2;
  logic clamp_d [0:CD-1];

  always_ff @(posedge clk) begin
    if (en) begin
      clamp_d[0] <= s_clamped;
      for (int i = 1; i < CD; i++) begin
        clamp_d[i] <= clamp_d[i-1];
      end
    end
  end

  assign pitch_clamped = clamp_d[CD-1];

endmodule

// ----- tb/sv/tb_quaternion_to_euler_degrees_core.sv -----
// Testbench for the quaternion to Euler angle converter: random and directed poses.
`timescale 1ns / 1ps
module tb_quaternion_to_euler_degrees_core;

  localparam int ITERS = 16;
  localparam int FRAC = 14;
  localparam int LATENCY = 38 + ITERS;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam longint WORK_ONE = 64'sd1 << 30;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] roll_deg;
  logic signed [14:0] pitch_deg;
  logic signed [15:0] yaw_deg;
  logic pitch_clamped;

  angles_t expected_angles[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  bit hold_request = 1'b0;

  quaternion_to_euler_degrees_core #(
    .CORDIC_ITERATIONS(ITERS),
    .COMPONENT_FRACTION_BITS(FRAC)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .roll_deg(roll_deg), .pitch_deg(pitch_deg), .yaw_deg(yaw_deg),
    .pitch_clamped(pitch_clamped)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Arithmetic shift right that rounds toward minus infinity.
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  // Degree angle from the arctangent table, 16 fraction bits.
  function automatic longint atan_step(int i);
    longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
                        14, 7, 4, 2, 1, 0};
    return tab[i];
  endfunction

  // Floor integer square root.
  function automatic longint floor_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC atan2 in degrees with 16 fraction bits.
  function automatic longint cordic_atan2(longint y, longint x);
    longint ang, t, nx, ny;
    ang = 0;
    if (y == 0) return (x >= 0) ? 0 : 180 * 65536;
    if (x == 0) return (y > 0) ? 90 * 65536 : -90 * 65536;
    if (x < 0) begin
      if (y > 0) begin
        t = x; x = y; y = -t; ang = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; ang = -90 * 65536;
      end
    end
    for (int i = 0; i < ITERS && i < 24; i++) begin
      if (y > 0) begin
        nx = x + shr_floor(y, i);
        ny = y - shr_floor(x, i);
        ang += atan_step(i);
      end else begin
        nx = x - shr_floor(y, i);
        ny = y + shr_floor(x, i);
        ang -= atan_step(i);
      end
      x = nx;
      y = ny;
    end
    return ang;
  endfunction

  // Round half up to 7 fraction bits and saturate.
  function automatic longint round_deg(longint a, longint lim);
    longint r;
    r = shr_floor(a + 256, 9);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_t predict_angles(logic signed [15:0] qw, logic signed [15:0] qx,
                                             logic signed [15:0] qy, logic signed [15:0] qz);
    longint w, x, y, z, unit, sa, tn, c;
    angles_t a;
    w = qw; x = qx; y = qy; z = qz;
    unit = 64'sd1 <<< (2 * FRAC);
    sa = -2 * (x * z - y * w);
    a.clamped = 1'b0;
    if (sa > unit) begin
      sa = unit; a.clamped = 1'b1;
    end else if (sa < -unit) begin
      sa = -unit; a.clamped = 1'b1;
    end
    tn = sa * (64'sd1 <<< (30 - 2 * FRAC));
    if (tn > WORK_ONE) tn = WORK_ONE;
    if (tn < -WORK_ONE) tn = -WORK_ONE;
    c = floor_sqrt(WORK_ONE * WORK_ONE - tn * tn);
    a.roll = 16'(round_deg(cordic_atan2(2 * (y * z + x * w), w*w - x*x - y*y + z*z), 23040));
    a.pitch = 15'(round_deg(cordic_atan2(tn, c), 11520));
    a.yaw = 16'(round_deg(cordic_atan2(2 * (x * y + z * w), w*w + x*x - y*y - z*z), 23040));
    return a;
  endfunction

  // Valid stays high between back-to-back requests and drops only for a gap.
  task automatic send_pose(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
    expected_angles.insert(expected_angles.size(), predict_angles(w, x, y, z));
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [15:0] rand_comp();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // Stop offering requests and wait for every outstanding result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
  endtask

  // Special cases: identity, axis rotations, gimbal lock, zero operands.
  task automatic test_directed();
    send_pose(16384, 0, 0, 0);
    send_pose(-16384, 0, 0, 0);
    send_pose(0, 16384, 0, 0);
    send_pose(0, 0, 16384, 0);
    send_pose(0, 0, 0, 16384);
    send_pose(0, 0, 0, -16384);
    send_pose(11585, 0, 11585, 0);
    send_pose(11585, 0, -11585, 0);
    send_pose(11586, 11586, 11586, 0);
    send_pose(0, 0, 0, 0);
    send_pose(16384, 16384, 16384, 16384);
    send_pose(-16384, -16384, 16384, 16384);
    send_pose(-16384, 16384, -16384, 16384);
    send_pose(11585, 11585, 0, 0);
    send_pose(11585, 0, 0, 11585);
    send_pose(8192, 8192, 8192, 8192);
    send_pose(8192, -8192, 8192, -8192);
    send_pose(1, -1, 1, -1);
    send_pose(-1, -1, -1, -1);
    send_pose(16383, -16383, 5461, -5462);
  endtask

  // Mostly near-unit quaternions, the rest unconstrained components.
  task automatic test_random(int count);
    real a, b, c, d, n;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_pose(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end else begin
        a = $itor($signed($urandom_range(0, 2000)) - 1000);
        b = $itor($signed($urandom_range(0, 2000)) - 1000);
        c = $itor($signed($urandom_range(0, 2000)) - 1000);
        d = $itor($signed($urandom_range(0, 2000)) - 1000);
        n = $sqrt(a*a + b*b + c*c + d*d);
        if (n < 1.0) n = 1.0;
        send_pose(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                  16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
      end
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall the input.
  task automatic test_backpressure();
    hold_off = 3 * LATENCY;
    hold_request = 1'b1;
    for (int i = 0; i < 120; i++) send_pose(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    wait_drained();
  endtask

  // Receiver side: random stalls, plus a long hold-off on request.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
      end
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    angles_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_angles.size() == 0) begin
        $display("%0t: result with no request pending: roll %0d pitch %0d yaw %0d",
                 $time, roll_deg, pitch_deg, yaw_deg);
        errors++;
      end else begin
        e = expected_angles.pop_front();
        if (roll_deg !== e.roll) begin
          $display("%0t: roll expected %0d actual %0d", $time, e.roll, roll_deg);
          errors++;
        end
        if (pitch_deg !== e.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, pitch_deg);
          errors++;
        end
        if (yaw_deg !== e.yaw) begin
          $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, yaw_deg);
          errors++;
        end
        if (pitch_clamped !== e.clamped) begin
          $display("%0t: clamp expected %0b actual %0b", $time, e.clamped, pitch_clamped);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL quaternion_to_euler_degrees_core");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    wait_drained();
    test_random(700);
    test_backpressure();
    test_random(660);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_angles.size() == 0) begin
      $display("PASS quaternion_to_euler_degrees_core");
    end else begin
      $display("FAIL quaternion_to_euler_degrees_core");
    end
    $finish;
  end

endmodule

// ----- quaternion_to_euler_degrees_core.f -----
rtl/qte_pkg.sv
rtl/qte_prep.sv
rtl/qte_isqrt.sv
rtl/qte_cordic.sv
rtl/quaternion_to_euler_degrees_core.sv
tb/sv/tb_quaternion_to_euler_degrees_core.sv
